// ===== rtl/core/rpsd_pkg.sv =====
// Shared types and constants for the raster pixel stream decoder.
// No dependencies; every other file of the block imports this package.
package rpsd_pkg;

  // Image formats held in the format register.
  localparam logic [2:0] FMT_P1 = 3'd0;
  localparam logic [2:0] FMT_P2 = 3'd1;
  localparam logic [2:0] FMT_P3 = 3'd2;
  localparam logic [2:0] FMT_P4 = 3'd3;
  localparam logic [2:0] FMT_P5 = 3'd4;
  localparam logic [2:0] FMT_P6 = 3'd5;
  localparam logic [2:0] FMT_P7 = 3'd6;
  localparam logic [2:0] FMT_FF = 3'd7;

  // Register indexes on the configuration port.
  localparam logic [2:0] CFG_FORMAT  = 3'd0;
  localparam logic [2:0] CFG_WIDTH   = 3'd1;
  localparam logic [2:0] CFG_HEIGHT  = 3'd2;
  localparam logic [2:0] CFG_MAXVAL  = 3'd3;
  localparam logic [2:0] CFG_SCALE   = 3'd4;
  localparam logic [2:0] CFG_DEPTH   = 3'd5;
  localparam logic [2:0] CFG_LAYOUT  = 3'd6;
  localparam int unsigned CFG_DATA_W = 40;

  // Result status codes.
  localparam logic [1:0] ST_PIXEL   = 2'd0;
  localparam logic [1:0] ST_EARLY   = 2'd1;
  localparam logic [1:0] ST_BADCHAR = 2'd2;
  localparam logic [1:0] ST_OVER    = 2'd3;

  // Channel layouts of the arbitrary map format.
  localparam logic [1:0] LAY_GRAY  = 2'd0;
  localparam logic [1:0] LAY_GRAYA = 2'd1;
  localparam logic [1:0] LAY_RGB   = 2'd2;
  localparam logic [1:0] LAY_RGBA  = 2'd3;

  // Size limits.
  localparam logic [17:0] MAX_ROW_PIXELS   = 18'd262136;
  localparam logic [18:0] MAX_IMAGE_ROWS   = 19'd458738;
  localparam logic [36:0] MAX_IMAGE_PIXELS = 37'd1879048192;

  // Characters of the plain formats.
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_ONE     = 8'h31;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;

  localparam logic [7:0] FULL8 = 8'hFF;

  typedef struct packed {
    logic [2:0]  format;
    logic [17:0] image_width;
    logic [18:0] image_height;
    logic [15:0] max_value;
    logic [39:0] scale_factor;
    logic [2:0]  sample_depth;
    logic [1:0]  channel_layout;
  } cfg_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [1:0] status;
    logic       last;
  } res_t;

endpackage

// ===== rtl/core/rpsd_scale.sv =====
// Sample scaling unit: turns a 16-bit sample into an 8-bit channel.
// Depends on rpsd_pkg for shared constants.
module rpsd_scale
  import rpsd_pkg::*;
(
  input  logic [15:0] sample,
  input  logic [39:0] scale_factor,
  input  logic        is_farbfeld,
  output logic [7:0]  value
);

  logic [55:0] prod;
  logic [23:0] prod_hi;
  logic [7:0]  sat_val;
  logic [15:0] ff_tmp;

  assign prod    = 56'(sample) * 56'(scale_factor);
  assign prod_hi = prod[55:32];
  assign sat_val = (|prod_hi[23:8]) ? FULL8 : prod_hi[7:0];

  // Floor division by 257 without a divider: v - (v >> 8), then take the high byte.
  assign ff_tmp = sample - {8'd0, sample[15:8]};

  assign value = is_farbfeld ? ff_tmp[15:8] : sat_val;

endmodule

// ===== rtl/core/rpsd_decode.sv =====
// Decoder state and per-cycle result generation for the pixel stream decoder.
// Depends on rpsd_pkg and instantiates rpsd_scale.
module rpsd_decode
  import rpsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       step_en,
  input  logic       item_fire,
  input  logic [7:0] data_byte,
  input  logic       end_of_data,
  output logic       busy,
  output logic       res_valid,
  output res_t       res
);

  logic [30:0] pix_cnt_r, pix_cnt_nxt;
  logic [17:0] col_cnt_r, col_cnt_nxt;
  logic        phase_r, phase_nxt;
  logic [7:0]  high_r, high_nxt;
  logic [7:0]  store_r [4];
  logic [7:0]  store_nxt [4];
  logic [1:0]  ch_idx_r, ch_idx_nxt;
  logic [15:0] num_r, num_nxt;
  logic        in_num_r, in_num_nxt;
  logic        in_cmt_r, in_cmt_nxt;
  logic        fin_r, fin_nxt;
  logic [7:0]  bm_byte_r, bm_byte_nxt;
  logic [2:0]  bm_cnt_r, bm_cnt_nxt;
  logic        pend_fail_r, pend_fail_nxt;

  logic [36:0] img_size;
  logic        size_ok;
  logic        active;
  logic [30:0] pc1;
  logic        pix_last;

  logic        is_text;
  logic        two_byte;
  logic [15:0] samp;
  logic [7:0]  samp_val;
  logic        samp_over;
  logic [2:0]  spp;
  logic [2:0]  ci1;
  logic        samp_pix;
  logic [7:0]  st_new [4];
  logic [7:0]  px_r, px_g, px_b, px_a;

  logic        is_digit, is_space;
  logic [19:0] nv;
  logic [8:0]  w_left;
  logic [17:0] w_diff;
  logic [3:0]  bm_cnt;
  logic [18:0] col_sum;

  logic        take_s;
  logic        text_post;

  assign img_size = 37'(cfg.image_width) * 37'(cfg.image_height);
  assign size_ok  = (cfg.image_width != '0) && (cfg.image_height != '0) &&
                    (cfg.image_width <= MAX_ROW_PIXELS) &&
                    (cfg.image_height <= MAX_IMAGE_ROWS) &&
                    (img_size <= MAX_IMAGE_PIXELS);
  assign active   = !fin_r && size_ok && ({6'd0, pix_cnt_r} < img_size);
  assign pc1      = pix_cnt_r + 31'd1;
  assign pix_last = ({6'd0, pc1} >= img_size);

  assign busy = (bm_cnt_r != '0) || pend_fail_r;

  assign is_text  = (cfg.format <= FMT_P3);
  assign two_byte = (cfg.format == FMT_FF) || (cfg.max_value > 16'd255);
  assign samp     = is_text ? num_r : (two_byte ? {high_r, data_byte} : {8'd0, data_byte});

  rpsd_scale u_scale (
    .sample       (samp),
    .scale_factor (cfg.scale_factor),
    .is_farbfeld  (cfg.format == FMT_FF),
    .value        (samp_val)
  );

  assign samp_over = (cfg.format != FMT_FF) && (samp > cfg.max_value);

  always_comb begin
    unique case (cfg.format)
      FMT_P3, FMT_P6: spp = 3'd3;
      FMT_P7: begin
        if (cfg.sample_depth == 3'd0) spp = 3'd1;
        else if (cfg.sample_depth > 3'd4) spp = 3'd4;
        else spp = cfg.sample_depth;
      end
      FMT_FF:  spp = 3'd4;
      default: spp = 3'd1;
    endcase
  end

  assign ci1      = {1'b0, ch_idx_r} + 3'd1;
  assign samp_pix = (ci1 >= spp);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      st_new[i] = (ch_idx_r == 2'(i)) ? samp_val : store_r[i];
    end
  end

  always_comb begin
    px_r = st_new[0];
    px_g = st_new[0];
    px_b = st_new[0];
    px_a = FULL8;
    case (cfg.format)
      FMT_P3, FMT_P6: begin
        px_g = st_new[1];
        px_b = st_new[2];
      end
      FMT_FF: begin
        px_g = st_new[1];
        px_b = st_new[2];
        px_a = st_new[3];
      end
      FMT_P7: begin
        case (cfg.channel_layout)
          LAY_GRAY:  px_a = FULL8;
          LAY_GRAYA: px_a = st_new[1];
          LAY_RGB: begin
            px_g = st_new[1];
            px_b = st_new[2];
          end
          default: begin
            px_g = st_new[1];
            px_b = st_new[2];
            px_a = st_new[3];
          end
        endcase
      end
      default: ;
    endcase
  end

  assign is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
  assign is_space = (data_byte == CH_SPACE) || ((data_byte >= CH_TAB) && (data_byte <= CH_CR));
  assign nv       = {1'b0, num_r, 3'd0} + {3'd0, num_r, 1'b0} + 20'(data_byte - CH_ZERO);

  assign w_diff  = cfg.image_width - col_cnt_r;
  assign w_left  = (w_diff > 18'd8) ? 9'd8 : w_diff[8:0];
  assign bm_cnt  = (col_cnt_r >= cfg.image_width) ? 4'd0 : w_left[3:0];
  assign col_sum = {1'b0, col_cnt_r} + 19'(bm_cnt);

  always_comb begin
    pix_cnt_nxt   = pix_cnt_r;
    col_cnt_nxt   = col_cnt_r;
    phase_nxt     = phase_r;
    high_nxt      = high_r;
    store_nxt     = store_r;
    ch_idx_nxt    = ch_idx_r;
    num_nxt       = num_r;
    in_num_nxt    = in_num_r;
    in_cmt_nxt    = in_cmt_r;
    fin_nxt       = fin_r;
    bm_byte_nxt   = bm_byte_r;
    bm_cnt_nxt    = bm_cnt_r;
    pend_fail_nxt = pend_fail_r;
    res_valid     = 1'b0;
    res           = '0;
    take_s        = 1'b0;
    text_post     = 1'b0;

    if (step_en && busy) begin
      if (pend_fail_r) begin
        res_valid     = 1'b1;
        res.status    = ST_BADCHAR;
        res.last      = 1'b1;
        fin_nxt       = 1'b1;
        pend_fail_nxt = 1'b0;
      end else begin
        res_valid   = 1'b1;
        res.red     = bm_byte_r[7] ? 8'd0 : FULL8;
        res.green   = bm_byte_r[7] ? 8'd0 : FULL8;
        res.blue    = bm_byte_r[7] ? 8'd0 : FULL8;
        res.alpha   = FULL8;
        res.status  = ST_PIXEL;
        res.last    = pix_last;
        pix_cnt_nxt = pc1;
        bm_byte_nxt = {bm_byte_r[6:0], 1'b0};
        bm_cnt_nxt  = bm_cnt_r - 3'd1;
        if (pix_last) begin
          fin_nxt    = 1'b1;
          bm_cnt_nxt = 3'd0;
        end
      end
    end else if (item_fire && active) begin
      if (end_of_data) begin
        res_valid  = 1'b1;
        res.status = ST_EARLY;
        res.last   = 1'b1;
        fin_nxt    = 1'b1;
      end else if (is_text) begin
        if (in_cmt_r) begin
          if (data_byte == CH_NEWLINE) in_cmt_nxt = 1'b0;
        end else if (cfg.format == FMT_P1) begin
          if (is_space) begin
            in_cmt_nxt = in_cmt_r;
          end else if (data_byte == CH_HASH) begin
            in_cmt_nxt = 1'b1;
          end else if ((data_byte == CH_ZERO) || (data_byte == CH_ONE)) begin
            res_valid   = 1'b1;
            res.red     = (data_byte == CH_ZERO) ? FULL8 : 8'd0;
            res.green   = (data_byte == CH_ZERO) ? FULL8 : 8'd0;
            res.blue    = (data_byte == CH_ZERO) ? FULL8 : 8'd0;
            res.alpha   = FULL8;
            res.status  = ST_PIXEL;
            res.last    = pix_last;
            pix_cnt_nxt = pc1;
            if (pix_last) fin_nxt = 1'b1;
          end else begin
            res_valid  = 1'b1;
            res.status = ST_BADCHAR;
            res.last   = 1'b1;
            fin_nxt    = 1'b1;
          end
        end else if (is_digit) begin
          in_num_nxt = 1'b1;
          if (nv > {4'd0, cfg.max_value}) begin
            res_valid  = 1'b1;
            res.status = ST_OVER;
            res.last   = 1'b1;
            fin_nxt    = 1'b1;
          end else begin
            num_nxt = nv[15:0];
          end
        end else begin
          if (in_num_r) begin
            in_num_nxt = 1'b0;
            num_nxt    = '0;
            take_s     = 1'b1;
          end
          text_post = 1'b1;
        end
      end else if (cfg.format == FMT_P4) begin
        col_cnt_nxt = (col_sum >= {1'b0, cfg.image_width}) ? 18'd0 : col_sum[17:0];
        if (bm_cnt != 4'd0) begin
          res_valid   = 1'b1;
          res.red     = data_byte[7] ? 8'd0 : FULL8;
          res.green   = data_byte[7] ? 8'd0 : FULL8;
          res.blue    = data_byte[7] ? 8'd0 : FULL8;
          res.alpha   = FULL8;
          res.status  = ST_PIXEL;
          res.last    = pix_last;
          pix_cnt_nxt = pc1;
          if (pix_last) begin
            fin_nxt = 1'b1;
          end else begin
            bm_byte_nxt = {data_byte[6:0], 1'b0};
            bm_cnt_nxt  = 3'(bm_cnt - 4'd1);
          end
        end
      end else begin
        if (two_byte && !phase_r) begin
          high_nxt  = data_byte;
          phase_nxt = 1'b1;
        end else begin
          phase_nxt = 1'b0;
          take_s    = 1'b1;
        end
      end
    end

    // One completed sample: range check, store, and possibly a pixel.
    if (take_s) begin
      if (samp_over) begin
        res_valid  = 1'b1;
        res.status = ST_OVER;
        res.last   = 1'b1;
        fin_nxt    = 1'b1;
      end else begin
        store_nxt[ch_idx_r] = samp_val;
        if (samp_pix) begin
          ch_idx_nxt  = 2'd0;
          res_valid   = 1'b1;
          res.red     = px_r;
          res.green   = px_g;
          res.blue    = px_b;
          res.alpha   = px_a;
          res.status  = ST_PIXEL;
          res.last    = pix_last;
          pix_cnt_nxt = pc1;
          if (pix_last) fin_nxt = 1'b1;
        end else begin
          ch_idx_nxt = ci1[1:0];
        end
      end
    end

    // The byte that ended a number is still checked as a separator.
    if (text_post && !(take_s && (samp_over || (samp_pix && pix_last)))) begin
      if (is_space) begin
        in_cmt_nxt = in_cmt_r;
      end else if (data_byte == CH_HASH) begin
        in_cmt_nxt = 1'b1;
      end else if (take_s && samp_pix) begin
        pend_fail_nxt = 1'b1;
      end else begin
        res_valid  = 1'b1;
        res.status = ST_BADCHAR;
        res.last   = 1'b1;
        fin_nxt    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_cnt_r   <= '0;
      col_cnt_r   <= '0;
      phase_r     <= 1'b0;
      high_r      <= '0;
      ch_idx_r    <= '0;
      num_r       <= '0;
      in_num_r    <= 1'b0;
      in_cmt_r    <= 1'b0;
      fin_r       <= 1'b0;
      bm_cnt_r    <= '0;
      pend_fail_r <= 1'b0;
    end else begin
      pix_cnt_r   <= pix_cnt_nxt;
      col_cnt_r   <= col_cnt_nxt;
      phase_r     <= phase_nxt;
      high_r      <= high_nxt;
      ch_idx_r    <= ch_idx_nxt;
      num_r       <= num_nxt;
      in_num_r    <= in_num_nxt;
      in_cmt_r    <= in_cmt_nxt;
      fin_r       <= fin_nxt;
      bm_cnt_r    <= bm_cnt_nxt;
      pend_fail_r <= pend_fail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bm_byte_r <= bm_byte_nxt;
    store_r   <= store_nxt;
  end

endmodule

// ===== rtl/core/raster_pixel_stream_decoder.sv =====
// Top level of the raster pixel stream decoder: configuration registers,
// result register and handshakes. Depends on rpsd_pkg and rpsd_decode.
//
// This block turns the body bytes of a PBM, PGM, PPM, PAM or farbfeld image
// into RGBA8 pixels, after software has parsed the header and written the
// configuration registers. Each input item is one body byte, or an end marker.
// Every item that yields at most one result is taken without a hold-off, so
// the block sustains one item per clock whenever the result side keeps up. A P4
// bitmap byte gives up to eight pixels, and a text separator that both
// completes a pixel and is a bad character gives two results. The first
// result is computed in the cycle that takes the item and registered; the
// decoder then drains the rest through the single result register at one per
// cycle while the result side keeps up, and holds off the next item until the
// extra results are out (up to seven for a bitmap byte). The path per cycle is
// one 16 by 40 scaling multiply with saturation in the sample unit. Decoding
// stops after the final pixel or any status item until reset.
module raster_pixel_stream_decoder
  import rpsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_alpha,
  output logic [1:0]  out_status,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t cfg_r;
  logic out_valid_r;
  res_t out_r;
  logic slot_free;
  logic busy;
  logic res_valid;
  res_t res;
  logic item_fire;

  // Configuration registers; writes land at once and leave the decode state alone.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.format         <= FMT_P1;
      cfg_r.image_width    <= 18'd1;
      cfg_r.image_height   <= 19'd1;
      cfg_r.max_value      <= 16'd255;
      cfg_r.scale_factor   <= 40'h01_0000_0000;
      cfg_r.sample_depth   <= 3'd1;
      cfg_r.channel_layout <= LAY_GRAY;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FORMAT: cfg_r.format         <= cfg_wdata[2:0];
        CFG_WIDTH:  cfg_r.image_width    <= cfg_wdata[17:0];
        CFG_HEIGHT: cfg_r.image_height   <= cfg_wdata[18:0];
        CFG_MAXVAL: cfg_r.max_value      <= cfg_wdata[15:0];
        CFG_SCALE:  cfg_r.scale_factor   <= cfg_wdata[39:0];
        CFG_DEPTH:  cfg_r.sample_depth   <= cfg_wdata[2:0];
        CFG_LAYOUT: cfg_r.channel_layout <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  // The result register can take a new result when empty or being emptied.
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = slot_free && !busy;
  assign item_fire = in_valid && in_ready;

  rpsd_decode u_decode (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .step_en     (slot_free),
    .item_fire   (item_fire),
    .data_byte   (in_data_byte),
    .end_of_data (in_end_of_data),
    .busy        (busy),
    .res_valid   (res_valid),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (slot_free) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_red    = out_r.red;
  assign out_green  = out_r.green;
  assign out_blue   = out_r.blue;
  assign out_alpha  = out_r.alpha;
  assign out_status = out_r.status;
  assign out_last   = out_r.last;

endmodule

// ===== rtl/core/rpsd_checker.sv =====
// Port-level assertions for the raster pixel stream decoder, bound to its top.
// Depends on rpsd_pkg and raster_pixel_stream_decoder.
module rpsd_checker
  import rpsd_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue,
  input logic [7:0] out_alpha,
  input logic [1:0] out_status,
  input logic       out_last
);

  // No result is shown in the cycle after a reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Every status item terminates the stream.
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_PIXEL) |-> out_last)
    else $error("status item without last");

  // Status items carry no color.
  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_PIXEL) |->
    (out_red == 8'd0 && out_green == 8'd0 && out_blue == 8'd0 && out_alpha == 8'd0))
    else $error("status item with nonzero channels");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
    (out_valid && $stable(out_red) && $stable(out_status) && $stable(out_last)))
    else $error("stalled result changed");

endmodule

bind raster_pixel_stream_decoder rpsd_checker u_rpsd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_red    (out_red),
  .out_green  (out_green),
  .out_blue   (out_blue),
  .out_alpha  (out_alpha),
  .out_status (out_status),
  .out_last   (out_last)
);
